FILE: hw/rtl/size_class_credit_dispatcher_macros.svh
// assertion macros shared by the dispatcher rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SIZE_CLASS_CREDIT_DISPATCHER_MACROS_SVH
`define SIZE_CLASS_CREDIT_DISPATCHER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SCCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SCCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sccd_pkg.sv
// shared types and constants for the size class credit dispatcher
// no dependencies
`default_nettype none

package sccd_pkg;

    localparam int CLASS_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_CLASSES     = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CU_W       = 3;
    localparam int LIMIT_W    = 8;
    localparam int ID_W       = 32;
    localparam int SIZE_W     = 32;
    localparam int CLASS_W    = 2;
    localparam int STATUS_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR0           = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR1           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR2           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT3         = 3'd7;

    localparam logic KIND_ARRIVAL    = 1'b0;
    localparam logic KIND_COMPLETION = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CTRL,
        S_POP
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/sccd_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none

module sccd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/size_class_credit_dispatcher.sv
// size class credit dispatcher top level: classifier, per-class credit and fifo control
// depends on sccd_pkg, sccd_ram and size_class_credit_dispatcher_macros.svh
//
// A job event is taken at a rising edge with i_start high and o_busy low. Each event
// gives exactly one result, shown on the o_ result ports for one cycle with o_valid
// high; the receiver cannot stall, so it must take every result in that cycle. An
// event is handled as one read of the per-class control memory, then the update and
// write-back, and the result is registered from the write-back; while it is shown the
// next event may already be taken. A completion that hands out a waiting job also reads
// the job id memory, in state S_POP, before its result is registered. Per-class control
// state starts cleared after reset with no clearing pass; the job id memory is not
// cleared and only entries written by a queued arrival are ever read.
`default_nettype none

`include "size_class_credit_dispatcher_macros.svh"

module size_class_credit_dispatcher #(
    parameter int CLASS_COUNT = sccd_pkg::CLASS_COUNT_DEF,
    parameter int QUEUE_DEPTH = sccd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic                              i_kind,
    input  wire logic [sccd_pkg::ID_W-1:0]         i_job_id,
    input  wire logic [sccd_pkg::SIZE_W-1:0]       i_job_size,
    input  wire logic                              i_cfg_we,
    input  wire logic [sccd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sccd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_valid,
    output logic                                   o_dispatched,
    output logic      [sccd_pkg::ID_W-1:0]         o_dispatched_id,
    output logic      [sccd_pkg::CLASS_W-1:0]      o_job_class,
    output logic      [sccd_pkg::STATUS_W-1:0]     o_status
);

    import sccd_pkg::*;

    localparam int CW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int IDEPTH = CLASS_COUNT * QUEUE_DEPTH;
    localparam int IAW   = $clog2(IDEPTH);
    localparam logic [QW:0]   FILL_FULL = (QW+1)'(QUEUE_DEPTH);
    localparam logic [QW-1:0] PTR_LAST  = QW'(QUEUE_DEPTH - 1);
    localparam logic [IAW-1:0] ROW_STEP = IAW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [QW:0]        fill;
        logic [QW-1:0]      head;
        logic [QW-1:0]      tail;
        logic [LIMIT_W-1:0] cnt;
    } t_ctrl;

    localparam int CTRL_W = $bits(t_ctrl);

    // configuration
    logic [CU_W-1:0]    r_cu;
    logic [SIZE_W-1:0]  r_thr   [MAX_CLASSES-1];
    logic [LIMIT_W-1:0] r_limit [MAX_CLASSES];

    // control
    t_state             r_state, n_state;
    logic               r_kind;
    logic [ID_W-1:0]    r_id;
    logic [CW-1:0]      r_class;
    logic               r_rd_vld;
    logic [CLASS_COUNT-1:0] r_ctrl_vld;

    // result registers
    logic               r_out_vld, n_out_vld;
    logic               r_disp, n_disp;
    logic [ID_W-1:0]    r_disp_id, n_disp_id;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [CU_W-1:0]    w_active;
    logic [CW-1:0]      w_pick;
    logic               w_ctrl_re, w_ctrl_we;
    t_ctrl              w_ctrl_rdata, w_ctrl_cur, w_ctrl_wr;
    logic               w_id_we, w_id_re;
    logic [IAW-1:0]     w_id_addr, w_row_base;
    logic [ID_W-1:0]    w_id_rdata;
    logic [LIMIT_W-1:0] w_lim, w_cnt_dec;

    // classes_in_use of zero acts as one, above the build count acts as the build count
    always_comb begin
        if (r_cu == '0) begin
            w_active = CU_W'(1);
        end else if (r_cu > CU_W'(CLASS_COUNT)) begin
            w_active = CU_W'(CLASS_COUNT);
        end else begin
            w_active = r_cu;
        end
    end

    always_comb begin
        w_pick = CW'(w_active - CU_W'(1));
        for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
            if ((CU_W'(i + 1) < w_active) && (i_job_size <= r_thr[i])) begin
                w_pick = CW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cu <= CU_W'(MAX_CLASSES);
            for (int i = 0; i < MAX_CLASSES - 1; i++) begin
                r_thr[i] <= '0;
            end
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_limit[i] <= LIMIT_W'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASSES_IN_USE: r_cu       <= i_cfg_data[CU_W-1:0];
                CFG_THR0:           r_thr[0]   <= i_cfg_data[SIZE_W-1:0];
                CFG_THR1:           r_thr[1]   <= i_cfg_data[SIZE_W-1:0];
                CFG_THR2:           r_thr[2]   <= i_cfg_data[SIZE_W-1:0];
                CFG_LIMIT0:         r_limit[0] <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT1:         r_limit[1] <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT2:         r_limit[2] <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT3:         r_limit[3] <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    sccd_ram #(
        .WIDTH (CTRL_W),
        .DEPTH (CLASS_COUNT)
    ) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl_we),
        .i_waddr (r_class),
        .i_wdata (w_ctrl_wr),
        .i_re    (w_ctrl_re),
        .i_raddr (w_pick),
        .o_rdata (w_ctrl_rdata)
    );

    sccd_ram #(
        .WIDTH (ID_W),
        .DEPTH (IDEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_id_we),
        .i_waddr (w_id_addr),
        .i_wdata (r_id),
        .i_re    (w_id_re),
        .i_raddr (w_id_addr),
        .o_rdata (w_id_rdata)
    );

    // a class never written since reset reads as all zero
    assign w_ctrl_cur = r_rd_vld ? w_ctrl_rdata : '0;
    assign w_lim      = r_limit[CLASS_W'(r_class)];
    assign w_cnt_dec  = w_ctrl_cur.cnt - LIMIT_W'(1);
    assign w_row_base = IAW'(r_class) * ROW_STEP;

    always_comb begin
        n_state   = r_state;
        w_ctrl_re = 1'b0;
        w_ctrl_we = 1'b0;
        w_ctrl_wr = w_ctrl_cur;
        w_id_we   = 1'b0;
        w_id_re   = 1'b0;
        w_id_addr = w_row_base + IAW'(w_ctrl_cur.tail);
        n_out_vld = 1'b0;
        n_disp    = 1'b0;
        n_disp_id = '0;
        n_status  = STATUS_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_ctrl_re = 1'b1;
                    n_state   = S_CTRL;
                end
            end
            S_CTRL: begin
                w_ctrl_we = 1'b1;
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
                if (r_kind == KIND_ARRIVAL) begin
                    if ((w_ctrl_cur.fill == '0) && (w_ctrl_cur.cnt < w_lim)) begin
                        w_ctrl_wr.cnt = w_ctrl_cur.cnt + LIMIT_W'(1);
                        n_disp        = 1'b1;
                        n_disp_id     = r_id;
                    end else if (w_ctrl_cur.fill != FILL_FULL) begin
                        w_id_we        = 1'b1;
                        w_ctrl_wr.tail = (w_ctrl_cur.tail == PTR_LAST) ? '0
                                         : w_ctrl_cur.tail + QW'(1);
                        w_ctrl_wr.fill = w_ctrl_cur.fill + (QW+1)'(1);
                    end else begin
                        n_status = STATUS_DROPPED;
                    end
                end else begin
                    if (w_ctrl_cur.cnt == '0) begin
                        n_status = STATUS_NONE;
                    end else if ((w_ctrl_cur.fill != '0) && (w_cnt_dec < w_lim)) begin
                        // credit goes straight back out to the head job, count unchanged
                        w_id_re        = 1'b1;
                        w_id_addr      = w_row_base + IAW'(w_ctrl_cur.head);
                        w_ctrl_wr.head = (w_ctrl_cur.head == PTR_LAST) ? '0
                                         : w_ctrl_cur.head + QW'(1);
                        w_ctrl_wr.fill = w_ctrl_cur.fill - (QW+1)'(1);
                        n_out_vld      = 1'b0;
                        n_state        = S_POP;
                    end else begin
                        w_ctrl_wr.cnt = w_cnt_dec;
                    end
                end
            end
            S_POP: begin
                n_out_vld = 1'b1;
                n_disp    = 1'b1;
                n_disp_id = w_id_rdata;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ctrl_vld <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (w_ctrl_re) begin
                r_rd_vld <= r_ctrl_vld[w_pick];
            end
            if (w_ctrl_we) begin
                r_ctrl_vld[r_class] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl_re) begin
            r_kind  <= i_kind;
            r_id    <= i_job_id;
            r_class <= w_pick;
        end
        if (n_out_vld) begin
            r_disp    <= n_disp;
            r_disp_id <= n_disp_id;
            r_status  <= n_status;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_out_vld;
    assign o_dispatched    = r_disp;
    assign o_dispatched_id = r_disp_id;
    assign o_job_class     = CLASS_W'(r_class);
    assign o_status        = r_status;

    `SCCD_ASSERT_NOW(a_valid_after_work, i_clk, i_rst_n, o_valid,
        ($past(r_state) == S_CTRL) || ($past(r_state) == S_POP),
        "result strobe without a finished event")
    `SCCD_ASSERT_NEXT(a_accept_reads_ctrl, i_clk, i_rst_n, i_start && !o_busy,
        r_state == S_CTRL, "accepted event did not enter the control read")
    `SCCD_ASSERT_NOW(a_flag_no_dispatch, i_clk, i_rst_n, o_valid && (o_status != STATUS_OK),
        !o_dispatched, "flagged event also dispatched a job")
    `SCCD_ASSERT_NOW(a_id_write_on_arrival, i_clk, i_rst_n, w_id_we,
        (r_kind == KIND_ARRIVAL) && (r_state == S_CTRL), "job id written outside an arrival")
    `SCCD_ASSERT_NOW(a_fill_bounded, i_clk, i_rst_n, w_ctrl_we,
        w_ctrl_wr.fill <= FILL_FULL, "queue fill beyond its depth")

endmodule

`default_nettype wire

FILE: bench/size_class_credit_dispatcher_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for size_class_credit_dispatcher: directed and random job events
// checked against a local model of class fifos and credits; depends on sccd_pkg and the rtl
module size_class_credit_dispatcher_tb;
    import sccd_pkg::*;

    localparam int CLASSES     = CLASS_COUNT_DEF;
    localparam int FIFO_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;
    localparam int SEGMENTS    = 13;
    localparam int SEG_ITEMS   = 150;

    typedef struct packed {
        logic                dispatched;
        logic [ID_W-1:0]     id;
        logic [CLASS_W-1:0]  job_class;
        logic [STATUS_W-1:0] status;
    } t_job_outcome;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    logic                  i_kind      = KIND_ARRIVAL;
    logic [ID_W-1:0]       i_job_id    = '0;
    logic [SIZE_W-1:0]     i_job_size  = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_CLASSES_IN_USE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_busy;
    logic                  o_valid;
    logic                  o_dispatched;
    logic [ID_W-1:0]       o_dispatched_id;
    logic [CLASS_W-1:0]    o_job_class;
    logic [STATUS_W-1:0]   o_status;

    // register copy and class state as the block should hold them
    logic [CU_W-1:0]    cfg_classes;
    logic [SIZE_W-1:0]  cfg_thr   [0:MAX_CLASSES-2];
    logic [LIMIT_W-1:0] cfg_limit [0:MAX_CLASSES-1];
    logic [ID_W-1:0]    waiting_ids [0:MAX_CLASSES-1][0:FIFO_DEPTH-1];
    int                 wait_head [0:MAX_CLASSES-1];
    int                 wait_fill [0:MAX_CLASSES-1];
    int                 in_flight [0:MAX_CLASSES-1];

    t_job_outcome pending_outcomes[$];
    int send_idle_pct = 0;
    int error_count   = 0;
    int events_sent   = 0;
    int dispatch_seen = 0;
    int drops_seen    = 0;
    int stray_seen    = 0;
    int cycle_count   = 0;

    size_class_credit_dispatcher i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_job_id       (i_job_id),
        .i_job_size     (i_job_size),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_dispatched   (o_dispatched),
        .o_dispatched_id(o_dispatched_id),
        .o_job_class    (o_job_class),
        .o_status       (o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("size_class_credit_dispatcher_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void reset_model();
        int k;
        cfg_classes = 3'd4;
        for (k = 0; k < MAX_CLASSES; k++) begin
            if (k < MAX_CLASSES - 1) cfg_thr[k] = '0;
            cfg_limit[k] = 8'd1;
            wait_head[k] = 0;
            wait_fill[k] = 0;
            in_flight[k] = 0;
        end
    endfunction

    function automatic int class_of(input logic [SIZE_W-1:0] size);
        int n;
        int k;
        n = int'(cfg_classes);
        if (n < 1) n = 1;
        if (n > CLASSES) n = CLASSES;
        for (k = 0; k < n - 1; k++) begin
            if (size <= cfg_thr[k]) return k;
        end
        return n - 1;
    endfunction

    // applies one job event to the class state and gives the result it should produce
    function automatic t_job_outcome predict_event(input logic kind, input logic [ID_W-1:0] id,
                                                   input logic [SIZE_W-1:0] size);
        t_job_outcome r;
        int c;
        c = class_of(size);
        r.dispatched = 1'b0;
        r.id         = '0;
        r.job_class  = c[CLASS_W-1:0];
        r.status     = STATUS_OK;
        if (kind == KIND_ARRIVAL) begin
            if (wait_fill[c] == 0 && in_flight[c] < cfg_limit[c]) begin
                in_flight[c]++;
                r.dispatched = 1'b1;
                r.id         = id;
            end else if (wait_fill[c] < FIFO_DEPTH) begin
                waiting_ids[c][(wait_head[c] + wait_fill[c]) % FIFO_DEPTH] = id;
                wait_fill[c]++;
            end else begin
                r.status = STATUS_DROPPED;
            end
        end else if (in_flight[c] == 0) begin
            r.status = STATUS_NONE;
        end else begin
            in_flight[c]--;
            // freed credit goes straight to the head of the class queue if the limit allows
            if (wait_fill[c] > 0 && in_flight[c] < cfg_limit[c]) begin
                r.id         = waiting_ids[c][wait_head[c]];
                r.dispatched = 1'b1;
                wait_head[c] = (wait_head[c] + 1) % FIFO_DEPTH;
                wait_fill[c]--;
                in_flight[c]++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_job_outcome want;
        if (i_rst_n && o_valid) begin
            if (o_dispatched === 1'b1) dispatch_seen++;
            if (o_status === STATUS_DROPPED) drops_seen++;
            if (o_status === STATUS_NONE) stray_seen++;
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result strobe with no event outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_dispatched !== want.dispatched)
                    report_mismatch($sformatf("dispatched %b, expected %b",
                                              o_dispatched, want.dispatched));
                if (o_dispatched_id !== want.id)
                    report_mismatch($sformatf("dispatched_id %h, expected %h",
                                              o_dispatched_id, want.id));
                if (o_job_class !== want.job_class)
                    report_mismatch($sformatf("job_class %0d, expected %0d",
                                              o_job_class, want.job_class));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
            end
        end
    end

    // start stays high after a transfer so back-to-back events need no second assignment
    task automatic send_job(input logic kind, input logic [ID_W-1:0] id,
                            input logic [SIZE_W-1:0] size);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_kind     <= kind;
        i_job_id   <= id;
        i_job_size <= size;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_outcomes.push_back(predict_event(kind, id, size));
        events_sent++;
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CLASSES_IN_USE: cfg_classes = data[CU_W-1:0];
            CFG_THR0:           cfg_thr[0] = data[SIZE_W-1:0];
            CFG_THR1:           cfg_thr[1] = data[SIZE_W-1:0];
            CFG_THR2:           cfg_thr[2] = data[SIZE_W-1:0];
            CFG_LIMIT0:         cfg_limit[0] = data[LIMIT_W-1:0];
            CFG_LIMIT1:         cfg_limit[1] = data[LIMIT_W-1:0];
            CFG_LIMIT2:         cfg_limit[2] = data[LIMIT_W-1:0];
            CFG_LIMIT3:         cfg_limit[3] = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CU_W-1:0] count,
                               input logic [SIZE_W-1:0] t0, input logic [SIZE_W-1:0] t1,
                               input logic [SIZE_W-1:0] t2,
                               input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                               input logic [LIMIT_W-1:0] l2, input logic [LIMIT_W-1:0] l3);
        write_reg(CFG_CLASSES_IN_USE, CFG_DATA_W'(count));
        write_reg(CFG_THR0, t0);
        write_reg(CFG_THR1, t1);
        write_reg(CFG_THR2, t2);
        write_reg(CFG_LIMIT0, CFG_DATA_W'(l0));
        write_reg(CFG_LIMIT1, CFG_DATA_W'(l1));
        write_reg(CFG_LIMIT2, CFG_DATA_W'(l2));
        write_reg(CFG_LIMIT3, CFG_DATA_W'(l3));
        i_cfg_we <= 1'b0;
    endtask

    // extremes, every class, dispatch, queueing, head pop and a completion with nothing out
    task automatic test_directed_basic();
        load_config(3'd4, 32'h10, 32'h1000, 32'hFFFF_FFFE, 8'd1, 8'd2, 8'd0, 8'd255);
        send_job(KIND_COMPLETION, 32'h0, 32'h0);
        send_job(KIND_ARRIVAL, 32'hFFFF_FFFF, 32'h0);
        send_job(KIND_ARRIVAL, 32'h0, 32'h10);
        send_job(KIND_ARRIVAL, 32'hA5A5_A5A5, 32'h11);
        send_job(KIND_ARRIVAL, 32'h5A5A_5A5A, 32'h1000);
        send_job(KIND_ARRIVAL, 32'h1234_5678, 32'h1000);
        send_job(KIND_ARRIVAL, 32'h8765_4321, 32'hFFFF_FFFE);
        send_job(KIND_ARRIVAL, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_job(KIND_COMPLETION, 32'hFFFF_FFFF, 32'h5);
        send_job(KIND_COMPLETION, 32'h0, 32'h11);
        send_job(KIND_COMPLETION, 32'h0, 32'hFFFF_FFFE);
        send_job(KIND_COMPLETION, 32'h0, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // limit dropped under the in-flight count, class count of zero and above range
    task automatic test_limit_and_count_changes();
        load_config(3'd4, 32'h10, 32'h1000, 32'hFFFF_FFFE, 8'd0, 8'd1, 8'd0, 8'd0);
        send_job(KIND_ARRIVAL, 32'h0BAD_F00D, 32'h11);
        send_job(KIND_COMPLETION, 32'h0, 32'h11);
        send_job(KIND_COMPLETION, 32'h0, 32'h11);
        send_job(KIND_ARRIVAL, 32'h7777_0000, 32'hFFFF_FFFE);
        wait_drained();
        load_config(3'd0, 32'h10, 32'h1000, 32'hFFFF_FFFE, 8'd1, 8'd1, 8'd3, 8'd255);
        send_job(KIND_ARRIVAL, 32'hC0DE_0001, 32'hFFFF_FFFF);
        send_job(KIND_COMPLETION, 32'h0, 32'h0);
        wait_drained();
        load_config(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    8'd255, 8'd255, 8'd255, 8'd255);
        send_job(KIND_ARRIVAL, 32'hC0DE_0002, 32'hFFFF_FFFF);
        send_job(KIND_COMPLETION, 32'h0, 32'h1000);
        send_job(KIND_COMPLETION, 32'h0, 32'hFFFF_FFFE);
        wait_drained();
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int k;
        k = $urandom_range(0, MAX_CLASSES - 2);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return cfg_thr[k];
            3:       return cfg_thr[k] + 1'b1;
            4:       return cfg_thr[k] - 1'b1;
            5:       return $urandom_range(0, 2000);
            default: return $urandom;
        endcase
    endfunction

    // a size whose class has work out, so the completion returns real credit
    function automatic logic [SIZE_W-1:0] size_with_credit_out();
        logic [SIZE_W-1:0] s;
        int tries;
        s = pick_size();
        tries = 0;
        while (tries < 12 && in_flight[class_of(s)] == 0) begin
            s = pick_size();
            tries++;
        end
        return s;
    endfunction

    task automatic randomize_config();
        logic [CU_W-1:0]    count;
        logic [SIZE_W-1:0]  t [0:2];
        logic [LIMIT_W-1:0] l [0:3];
        int k;
        case ($urandom_range(0, 9))
            0:       count = 3'd0;
            1:       count = CU_W'($urandom_range(CLASSES + 1, 7));
            default: count = CU_W'($urandom_range(1, CLASSES));
        endcase
        case ($urandom_range(0, 3))
            0: begin
                for (k = 0; k < 3; k++) t[k] = $urandom;
            end
            1: begin
                for (k = 0; k < 3; k++) t[k] = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                // ascending small thresholds so every class sees traffic
                t[0] = $urandom_range(0, 500);
                t[1] = t[0] + $urandom_range(0, 700);
                t[2] = t[1] + $urandom_range(0, 700);
            end
        endcase
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0:       l[k] = 8'd0;
                1:       l[k] = 8'd255;
                default: l[k] = LIMIT_W'($urandom_range(1, 4));
            endcase
        end
        load_config(count, t[0], t[1], t[2], l[0], l[1], l[2], l[3]);
    endtask

    task automatic run_random_segment(input int idle_pct);
        int left;
        int burst;
        logic [SIZE_W-1:0] s;
        send_idle_pct = idle_pct;
        wait_drained();
        randomize_config();
        left = SEG_ITEMS;
        while (left > 0) begin
            case ($urandom_range(0, 11))
                0: begin
                    // run of arrivals into one class, long enough to overflow its queue
                    s = pick_size();
                    burst = $urandom_range(FIFO_DEPTH, FIFO_DEPTH + 4);
                    repeat (burst) send_job(KIND_ARRIVAL, $urandom, s);
                    left -= burst;
                end
                1, 2: begin
                    s = size_with_credit_out();
                    burst = $urandom_range(1, FIFO_DEPTH + 2);
                    repeat (burst) send_job(KIND_COMPLETION, $urandom, s);
                    left -= burst;
                end
                3: begin
                    send_job(KIND_COMPLETION, $urandom, pick_size());
                    left--;
                end
                4, 5, 6: begin
                    send_job(KIND_ARRIVAL, $urandom, pick_size());
                    left--;
                end
                default: begin
                    send_job(KIND_COMPLETION, $urandom, size_with_credit_out());
                    left--;
                end
            endcase
        end
    endtask

    initial begin
        int seg;
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 7;
        test_directed_basic();
        test_limit_and_count_changes();
        for (seg = 0; seg < SEGMENTS; seg++) begin
            run_random_segment(seg < 4 ? 7 : (seg < 9 ? 47 : 0));
        end
        wait_drained();
        $display("%0d job events over %0d random register settings and three sender gap rates",
                 events_sent, SEGMENTS);
        $display("%0d dispatches, %0d full-queue drops, %0d completions with nothing out",
                 dispatch_seen, drops_seen, stray_seen);
        if (error_count == 0) begin
            $display("size_class_credit_dispatcher_tb: clean");
        end else begin
            $display("size_class_credit_dispatcher_tb: errors");
        end
        $finish;
    end

endmodule
